FILE: rtl/core/swlfc_pkg.sv
// ----------------------------------------------------------------------------
// Sliding-window link flow control package
// Shared types, event and result codes, and the slot arithmetic used by the
// front end, the command queue and the sequencing back end.
// ----------------------------------------------------------------------------
package swlfc_pkg;

  // Default window sizes, handed to the top level as parameter defaults.
  localparam int unsigned SEND_WINDOW_DEFAULT = 8;
  localparam int unsigned RECV_WINDOW_DEFAULT = 8;

  // Entries in the queue between front end and back end.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Event codes on the input channel.
  localparam logic [2:0] OP_SEND    = 3'd0;
  localparam logic [2:0] OP_ACK     = 3'd1;
  localparam logic [2:0] OP_DATA    = 3'd2;
  localparam logic [2:0] OP_TIMEOUT = 3'd3;
  localparam logic [2:0] OP_SYNC    = 3'd4;

  // Result kinds on the output channel.
  localparam logic [2:0] KIND_TX_NEW    = 3'd0;
  localparam logic [2:0] KIND_RETX      = 3'd1;
  localparam logic [2:0] KIND_FREED     = 3'd2;
  localparam logic [2:0] KIND_DELIVER   = 3'd3;
  localparam logic [2:0] KIND_SEND_ACK  = 3'd4;
  localparam logic [2:0] KIND_CONNECTED = 3'd5;
  localparam logic [2:0] KIND_REFUSED   = 3'd6;
  localparam logic [2:0] KIND_IGNORED   = 3'd7;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] seq;
    logic [7:0] peer_expected;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] seq_out;
    logic [2:0] slot;
    logic       last;
  } out_item_t;

  // Decoded command class as it travels through the queue.
  typedef enum logic [2:0] {
    CMD_SEND,
    CMD_ACK,
    CMD_DATA,
    CMD_TIMEOUT,
    CMD_SYNC,
    CMD_IGNORE
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] seq;
    logic [7:0] peer_expected;
  } cmd_t;

  // Remainder of an 8-bit value by a constant window size. The quotient comes
  // from a multiply by recip = ceil(2^16 / divisor), which is exact for every
  // 8-bit value and any divisor from 1 to 255; the remainder is what is left
  // after taking quotient times divisor off the value.
  function automatic logic [7:0] mod_by(input logic [7:0]  value,
                                        input logic [7:0]  divisor,
                                        input logic [16:0] recip);
    logic [24:0] prod;
    logic [7:0]  quo;
    logic [15:0] back;
    prod = {17'd0, value} * {8'd0, recip};
    quo  = prod[23:16];
    back = {8'd0, quo} * {8'd0, divisor};
    return value - back[7:0];
  endfunction

endpackage

FILE: rtl/core/sliding_window_link_flow_control_top.sv
// ----------------------------------------------------------------------------
// Sliding-window link flow control
// Sequence and window bookkeeping for a selective-repeat link with 8-bit
// modular sequence numbers.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake             Payload                 Transfer carries
//   -------  --------------------  ----------------------  --------------------
//   input    in_valid_i/in_ready_o in_item_i  (in_item_t)  one link event
//   output   out_valid_o/out_ready_i out_item_o (out_item_t) one result item
//
// An event passes the front register and the command queue before the back
// end takes it. The back end issues one result per cycle unless the output
// stalls; an event holds it until its results are out: one for send, sync,
// ignored events and refused or ignored acks and frames; a dispatch step and
// one per freed slot for an ack; a dispatch step, one per released frame and
// an ack for an in-order frame; a slot memory read and its result for a
// timeout. Reset, asynchronous and active low, clears all window state at
// once, and events are taken from its release. An output stall holds the
// back end; the queue and front register keep taking events until full.
//
module sliding_window_link_flow_control_top #(
  parameter int unsigned SEND_WINDOW = swlfc_pkg::SEND_WINDOW_DEFAULT,
  parameter int unsigned RECV_WINDOW = swlfc_pkg::RECV_WINDOW_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  swlfc_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output swlfc_pkg::out_item_t out_item_o
);

  // Decoded commands from the front end into the queue.
  logic            fe_valid;
  logic            fe_ready;
  swlfc_pkg::cmd_t fe_cmd;

  // Commands from the queue into the back end.
  logic            be_valid;
  logic            be_ready;
  swlfc_pkg::cmd_t be_cmd;

  // The front end registers each event and sorts it into a command class.
  // Unknown event codes become an ignore command here, so the back end never
  // sees a raw code.
  swlfc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (fe_valid),
    .cmd_ready_i (fe_ready),
    .cmd_o       (fe_cmd)
  );

  // The queue lets the front end keep accepting events while the back end
  // works through a long acknowledgement or release run.
  swlfc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_cmd_i   (fe_cmd),
    .pop_valid_o  (be_valid),
    .pop_ready_i  (be_ready),
    .pop_cmd_o    (be_cmd)
  );

  // The back end owns the windows, the hold and received flags and the slot
  // sequence memory. It walks slots one per cycle unless the output stalls,
  // and writes each result into its output register, stable under a stall.
  swlfc_back #(
    .SEND_WINDOW (SEND_WINDOW),
    .RECV_WINDOW (RECV_WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (be_valid),
    .cmd_ready_o (be_ready),
    .cmd_i       (be_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: rtl/core/swlfc_front.sv
// ----------------------------------------------------------------------------
// Sliding-window link front end
// Accepts input events into a register and classifies each into a command.
// ----------------------------------------------------------------------------
module swlfc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  swlfc_pkg::in_item_t  in_item_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output swlfc_pkg::cmd_t      cmd_o
);

  logic            valid_q;
  logic            valid_d;
  swlfc_pkg::cmd_t cmd_q;
  swlfc_pkg::cmd_t cmd_d;
  logic            accept;

  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    cmd_d.seq           = in_item_i.seq;
    cmd_d.peer_expected = in_item_i.peer_expected;
    case (in_item_i.op)
      swlfc_pkg::OP_SEND:    cmd_d.cmd = swlfc_pkg::CMD_SEND;
      swlfc_pkg::OP_ACK:     cmd_d.cmd = swlfc_pkg::CMD_ACK;
      swlfc_pkg::OP_DATA:    cmd_d.cmd = swlfc_pkg::CMD_DATA;
      swlfc_pkg::OP_TIMEOUT: cmd_d.cmd = swlfc_pkg::CMD_TIMEOUT;
      swlfc_pkg::OP_SYNC:    cmd_d.cmd = swlfc_pkg::CMD_SYNC;
      default:               cmd_d.cmd = swlfc_pkg::CMD_IGNORE;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

FILE: rtl/core/swlfc_queue.sv
// ----------------------------------------------------------------------------
// Sliding-window link command queue
// A short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module swlfc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  swlfc_pkg::cmd_t push_cmd_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output swlfc_pkg::cmd_t pop_cmd_o
);

  localparam int unsigned Depth = swlfc_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  swlfc_pkg::cmd_t entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q;
  logic [PtrW-1:0] rd_ptr_d;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  logic            push;
  logic            pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

FILE: rtl/core/swlfc_back.sv
// ----------------------------------------------------------------------------
// Sliding-window link back end
// Holds the window state and carries out one command at a time, issuing
// one result per cycle into an output register unless the output stalls.
// ----------------------------------------------------------------------------
module swlfc_back #(
  parameter int unsigned SEND_WINDOW = swlfc_pkg::SEND_WINDOW_DEFAULT,
  parameter int unsigned RECV_WINDOW = swlfc_pkg::RECV_WINDOW_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  swlfc_pkg::cmd_t      cmd_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output swlfc_pkg::out_item_t out_item_o
);

  localparam int unsigned SlotW  = (SEND_WINDOW > 1) ? $clog2(SEND_WINDOW) : 1;
  localparam int unsigned RslotW = (RECV_WINDOW > 1) ? $clog2(RECV_WINDOW) : 1;
  localparam int unsigned CntW   = $clog2(RECV_WINDOW + 1);
  localparam logic [7:0]      SendWin8   = 8'(SEND_WINDOW);
  localparam logic [8:0]      SendWin9   = 9'(SEND_WINDOW);
  localparam logic [7:0]      RecvWin8   = 8'(RECV_WINDOW);
  localparam logic [8:0]      RecvWin9   = 9'(RECV_WINDOW);
  localparam logic [CntW-1:0] RecvWinCnt = CntW'(RECV_WINDOW);
  // Reciprocals of the window sizes for the slot remainder.
  localparam logic [16:0]     SendRecip  = 17'((65536 + SEND_WINDOW - 1) / SEND_WINDOW);
  localparam logic [16:0]     RecvRecip  = 17'((65536 + RECV_WINDOW - 1) / RECV_WINDOW);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACK  = 2'd1;
  localparam logic [1:0] ST_DATA = 2'd2;
  localparam logic [1:0] ST_TMO  = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [7:0]             last_sent_q, last_sent_d;
  logic [7:0]             last_acked_q, last_acked_d;
  logic [7:0]             next_exp_q, next_exp_d;
  logic [SEND_WINDOW-1:0] held_q, held_d;
  logic [RECV_WINDOW-1:0] present_q, present_d;
  logic                   synack_wait_q, synack_wait_d;
  logic [7:0]             synack_num_q, synack_num_d;
  logic [7:0]             target_q, target_d;
  logic [CntW-1:0]        rel_cnt_q, rel_cnt_d;
  logic                   out_valid_q, out_valid_d;
  swlfc_pkg::out_item_t   out_q;

  // Sequence number held by each send slot.
  logic [7:0]             slot_seq_mem [SEND_WINDOW];
  logic [7:0]             mem_rd_q;
  logic                   mem_we;
  logic [SlotW-1:0]       mem_waddr;
  logic [7:0]             mem_wdata;
  logic                   mem_re;
  logic [SlotW-1:0]       mem_raddr;

  logic                   can_emit;
  logic                   dispatch;
  logic                   emit;
  swlfc_pkg::out_item_t   emit_item;

  logic [7:0] nxt_seq, nxt_mod;
  logic [7:0] outstanding;
  logic       send_full;
  logic [7:0] ack_pos;
  logic       ack_in;
  logic [7:0] data_pos;
  logic       data_in;
  logic [7:0] data_mod;
  logic [7:0] cmd_mod;
  logic [7:0] sync_mod;
  logic [7:0] free_seq, free_mod;
  logic       free_last;
  logic [7:0] ne_mod;
  logic [7:0] ne_prev;
  logic [7:0] tmo_mod;
  logic [7:0] pexp_prev;

  assign can_emit    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = (state_q == ST_IDLE) && can_emit;
  assign dispatch    = cmd_valid_i && cmd_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign nxt_seq     = last_sent_q + 8'd1;
  assign nxt_mod     = swlfc_pkg::mod_by(nxt_seq, SendWin8, SendRecip);
  assign outstanding = last_sent_q - last_acked_q;
  assign send_full   = {1'b0, outstanding} >= SendWin9;
  assign ack_pos     = cmd_i.seq - (last_acked_q + 8'd1);
  assign ack_in      = ack_pos < outstanding;
  assign data_pos    = cmd_i.seq - next_exp_q;
  assign data_in     = {1'b0, data_pos} < RecvWin9;
  assign data_mod    = swlfc_pkg::mod_by(cmd_i.seq, RecvWin8, RecvRecip);
  assign cmd_mod     = swlfc_pkg::mod_by(cmd_i.seq, SendWin8, SendRecip);
  assign sync_mod    = swlfc_pkg::mod_by(cmd_i.peer_expected, SendWin8, SendRecip);
  assign pexp_prev   = cmd_i.peer_expected - 8'd1;
  assign free_seq    = last_acked_q + 8'd1;
  assign free_mod    = swlfc_pkg::mod_by(free_seq, SendWin8, SendRecip);
  assign free_last   = (free_seq == target_q);
  assign ne_mod      = swlfc_pkg::mod_by(next_exp_q, RecvWin8, RecvRecip);
  assign ne_prev     = next_exp_q - 8'd1;
  assign tmo_mod     = swlfc_pkg::mod_by(target_q, SendWin8, SendRecip);

  always_comb begin
    state_d       = state_q;
    last_sent_d   = last_sent_q;
    last_acked_d  = last_acked_q;
    next_exp_d    = next_exp_q;
    held_d        = held_q;
    present_d     = present_q;
    synack_wait_d = synack_wait_q;
    synack_num_d  = synack_num_q;
    target_d      = target_q;
    rel_cnt_d     = rel_cnt_q;
    mem_we        = 1'b0;
    mem_waddr     = nxt_mod[SlotW-1:0];
    mem_wdata     = nxt_seq;
    mem_re        = 1'b0;
    mem_raddr     = cmd_mod[SlotW-1:0];
    emit          = 1'b0;
    emit_item     = '{kind: swlfc_pkg::KIND_IGNORED, seq_out: cmd_i.seq, slot: 3'd0,
                      last: 1'b1};

    case (state_q)
      ST_IDLE: begin
        if (dispatch) begin
          case (cmd_i.cmd)
            swlfc_pkg::CMD_SEND: begin
              emit = 1'b1;
              if (send_full) begin
                emit_item = '{kind: swlfc_pkg::KIND_REFUSED, seq_out: nxt_seq,
                              slot: nxt_mod[2:0], last: 1'b1};
              end else begin
                last_sent_d                  = nxt_seq;
                held_d[nxt_mod[SlotW-1:0]]   = 1'b1;
                mem_we                       = 1'b1;
                emit_item = '{kind: swlfc_pkg::KIND_TX_NEW, seq_out: nxt_seq,
                              slot: nxt_mod[2:0], last: 1'b1};
              end
            end
            swlfc_pkg::CMD_ACK: begin
              if (ack_in) begin
                target_d = cmd_i.seq;
                state_d  = ST_ACK;
                if (synack_wait_q && (synack_num_q == cmd_i.seq)) begin
                  synack_wait_d = 1'b0;
                  emit          = 1'b1;
                  emit_item = '{kind: swlfc_pkg::KIND_CONNECTED, seq_out: cmd_i.seq,
                                slot: 3'd0, last: 1'b0};
                end
              end else begin
                emit = 1'b1;
              end
            end
            swlfc_pkg::CMD_DATA: begin
              if (data_in) begin
                present_d[data_mod[RslotW-1:0]] = 1'b1;
                if (cmd_i.seq == next_exp_q) begin
                  rel_cnt_d = '0;
                  state_d   = ST_DATA;
                end else begin
                  emit      = 1'b1;
                  emit_item = '{kind: swlfc_pkg::KIND_SEND_ACK, seq_out: ne_prev,
                                slot: 3'd0, last: 1'b1};
                end
              end else begin
                emit = 1'b1;
              end
            end
            swlfc_pkg::CMD_TIMEOUT: begin
              mem_re   = 1'b1;
              target_d = cmd_i.seq;
              state_d  = ST_TMO;
            end
            swlfc_pkg::CMD_SYNC: begin
              held_d                       = '0;
              held_d[sync_mod[SlotW-1:0]]  = 1'b1;
              present_d                    = '0;
              next_exp_d                   = cmd_i.seq;
              last_acked_d                 = pexp_prev;
              last_sent_d                  = cmd_i.peer_expected;
              mem_we                       = 1'b1;
              mem_waddr                    = sync_mod[SlotW-1:0];
              mem_wdata                    = cmd_i.peer_expected;
              synack_wait_d                = 1'b1;
              synack_num_d                 = cmd_i.peer_expected;
              emit                         = 1'b1;
              emit_item = '{kind: swlfc_pkg::KIND_TX_NEW, seq_out: cmd_i.peer_expected,
                            slot: sync_mod[2:0], last: 1'b1};
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_ACK: begin
        // Free one slot per cycle while the output is not stalled, oldest first, up to the acknowledged number.
        if (can_emit) begin
          last_acked_d                 = free_seq;
          held_d[free_mod[SlotW-1:0]]  = 1'b0;
          emit                         = 1'b1;
          emit_item = '{kind: swlfc_pkg::KIND_FREED, seq_out: free_seq,
                        slot: free_mod[2:0], last: free_last};
          if (free_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_DATA: begin
        // Release the contiguous run of received frames, then acknowledge.
        if (can_emit) begin
          emit = 1'b1;
          if ((rel_cnt_q < RecvWinCnt) && present_q[ne_mod[RslotW-1:0]]) begin
            present_d[ne_mod[RslotW-1:0]] = 1'b0;
            next_exp_d                    = next_exp_q + 8'd1;
            rel_cnt_d                     = rel_cnt_q + CntW'(1);
            emit_item = '{kind: swlfc_pkg::KIND_DELIVER, seq_out: next_exp_q,
                          slot: ne_mod[2:0], last: 1'b0};
          end else begin
            state_d   = ST_IDLE;
            emit_item = '{kind: swlfc_pkg::KIND_SEND_ACK, seq_out: ne_prev,
                          slot: 3'd0, last: 1'b1};
          end
        end
      end
      ST_TMO: begin
        if (can_emit) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
          if (held_q[tmo_mod[SlotW-1:0]] && (mem_rd_q == target_q)) begin
            emit_item = '{kind: swlfc_pkg::KIND_RETX, seq_out: target_q,
                          slot: tmo_mod[2:0], last: 1'b1};
          end else begin
            emit_item = '{kind: swlfc_pkg::KIND_IGNORED, seq_out: target_q,
                          slot: 3'd0, last: 1'b1};
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      last_sent_q   <= '0;
      last_acked_q  <= '0;
      next_exp_q    <= '0;
      held_q        <= '0;
      present_q     <= '0;
      synack_wait_q <= 1'b0;
      synack_num_q  <= '0;
      target_q      <= '0;
      rel_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      last_sent_q   <= last_sent_d;
      last_acked_q  <= last_acked_d;
      next_exp_q    <= next_exp_d;
      held_q        <= held_d;
      present_q     <= present_d;
      synack_wait_q <= synack_wait_d;
      synack_num_q  <= synack_num_d;
      target_q      <= target_d;
      rel_cnt_q     <= rel_cnt_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= emit_item;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_seq_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rd_q <= slot_seq_mem[mem_raddr];
    end
  end

endmodule

FILE: bench/tb_sliding_window_link_flow_control_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the sliding-window link flow control block
// Drives link events through the valid/ready input channel and checks every
// result transfer against a cycle-free model of the send and receive windows.
// The run covers directed corner cases, then random link sessions, a long
// receiver hold-off, and a final stream without idling.
// ----------------------------------------------------------------------------
module tb_sliding_window_link_flow_control_top;

  localparam int SW           = swlfc_pkg::SEND_WINDOW_DEFAULT;
  localparam int RW           = swlfc_pkg::RECV_WINDOW_DEFAULT;
  localparam int CLK_PERIOD   = 20;
  // Longest run of cycles with no transfer on either channel before the run
  // is declared hung. The longest legal quiet stretch is the receiver
  // hold-off below, so this leaves a wide margin.
  localparam int STALL_LIMIT  = 1000;
  localparam int HOLD_CYCLES  = 80;
  // Cycles to wait after the last expected result, so that a stray extra
  // result from the back end still gets caught.
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_PRINTS   = 20;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  swlfc_pkg::in_item_t  in_item_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  swlfc_pkg::out_item_t out_item_o;

  sliding_window_link_flow_control_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Window model. It mirrors the block's bookkeeping: the outstanding send
  // range is link_last_acked+1 .. link_last_sent, and the receive window
  // starts at link_next_rx.
  // --------------------------------------------------------------------------
  logic [7:0]    link_last_sent;
  logic [7:0]    link_last_acked;
  logic [7:0]    link_next_rx;
  logic [SW-1:0] link_held;
  logic [7:0]    link_slot_seq [SW];
  logic [RW-1:0] link_rx_present;
  logic          link_synack_open;
  logic [7:0]    link_synack_seq;
  // Slots whose number memory has been written at least once. The slot
  // memory has no reset, so a timeout is only aimed at a written slot.
  logic [SW-1:0] link_slot_written;

  swlfc_pkg::out_item_t step_results[$];
  swlfc_pkg::out_item_t pending_results[$];

  // Test-wide controls and counters.
  bit quiet_mode    = 1'b0;
  bit tx_steady     = 1'b0;
  bit rx_calm       = 1'b0;
  int rx_hold_cycles = 0;
  int mismatch_count = 0;
  int events_sent    = 0;
  int results_seen   = 0;
  int input_stalls   = 0;
  int idle_cycles    = 0;
  int kind_seen [8];
  swlfc_pkg::out_item_t want_result;

  function automatic logic [2:0] tx_slot(input logic [7:0] s);
    logic [7:0] m;
    m = 8'(s % SW);
    return m[2:0];
  endfunction

  function automatic logic [2:0] rx_slot(input logic [7:0] s);
    logic [7:0] m;
    m = 8'(s % RW);
    return m[2:0];
  endfunction

  function automatic void add_result(input logic [2:0] kind, input logic [7:0] seqv,
                                     input logic [2:0] slotv);
    swlfc_pkg::out_item_t r;
    r.kind    = kind;
    r.seq_out = seqv;
    r.slot    = slotv;
    r.last    = 1'b0;
    step_results.push_back(r);
  endfunction

  // Hands out the next sequence number, or refuses when the window is full.
  function automatic void open_frame();
    logic [7:0] nxt;
    logic [7:0] outstanding;
    nxt         = link_last_sent + 8'd1;
    outstanding = link_last_sent - link_last_acked;
    if (outstanding >= SW) begin
      add_result(swlfc_pkg::KIND_REFUSED, nxt, tx_slot(nxt));
    end else begin
      link_last_sent                 = nxt;
      link_held[tx_slot(nxt)]         = 1'b1;
      link_slot_seq[tx_slot(nxt)]     = nxt;
      link_slot_written[tx_slot(nxt)] = 1'b1;
      add_result(swlfc_pkg::KIND_TX_NEW, nxt, tx_slot(nxt));
    end
  endfunction

  function automatic void clear_link_model();
    link_last_sent    = '0;
    link_last_acked   = '0;
    link_next_rx      = '0;
    link_held         = '0;
    link_rx_present   = '0;
    link_synack_open  = 1'b0;
    link_synack_seq   = '0;
    link_slot_written = '0;
    foreach (link_slot_seq[i]) link_slot_seq[i] = '0;
  endfunction

  // Works out the results of one accepted event and queues them in order.
  function automatic void predict_link_event(input swlfc_pkg::in_item_t ev);
    logic [7:0]           pos;
    logic [7:0]           span;
    swlfc_pkg::out_item_t r;
    int                   k;
    step_results.delete();
    case (ev.op)
      swlfc_pkg::OP_SEND: begin
        open_frame();
      end
      swlfc_pkg::OP_ACK: begin
        pos  = ev.seq - link_last_acked - 8'd1;
        span = link_last_sent - link_last_acked;
        if (pos < span) begin
          if (link_synack_open && link_synack_seq == ev.seq) begin
            link_synack_open = 1'b0;
            add_result(swlfc_pkg::KIND_CONNECTED, ev.seq, 3'd0);
          end
          // Cumulative: every slot up to and including the acked number.
          do begin
            link_last_acked = link_last_acked + 8'd1;
            link_held[tx_slot(link_last_acked)] = 1'b0;
            add_result(swlfc_pkg::KIND_FREED, link_last_acked, tx_slot(link_last_acked));
          end while (link_last_acked != ev.seq);
        end else begin
          add_result(swlfc_pkg::KIND_IGNORED, ev.seq, 3'd0);
        end
      end
      swlfc_pkg::OP_DATA: begin
        pos = ev.seq - link_next_rx;
        if (pos < RW) begin
          link_rx_present[rx_slot(ev.seq)] = 1'b1;
          if (ev.seq == link_next_rx) begin
            k = 0;
            while (k < RW && link_rx_present[rx_slot(link_next_rx)]) begin
              link_rx_present[rx_slot(link_next_rx)] = 1'b0;
              add_result(swlfc_pkg::KIND_DELIVER, link_next_rx, rx_slot(link_next_rx));
              link_next_rx = link_next_rx + 8'd1;
              k++;
            end
          end
          add_result(swlfc_pkg::KIND_SEND_ACK, link_next_rx - 8'd1, 3'd0);
        end else begin
          add_result(swlfc_pkg::KIND_IGNORED, ev.seq, 3'd0);
        end
      end
      swlfc_pkg::OP_TIMEOUT: begin
        if (link_held[tx_slot(ev.seq)] && link_slot_seq[tx_slot(ev.seq)] == ev.seq) begin
          add_result(swlfc_pkg::KIND_RETX, ev.seq, tx_slot(ev.seq));
        end else begin
          add_result(swlfc_pkg::KIND_IGNORED, ev.seq, 3'd0);
        end
      end
      swlfc_pkg::OP_SYNC: begin
        link_held       = '0;
        link_rx_present = '0;
        link_next_rx    = ev.seq;
        link_last_sent  = ev.peer_expected - 8'd1;
        link_last_acked = link_last_sent;
        open_frame();
        link_synack_open = 1'b1;
        link_synack_seq  = link_last_sent;
      end
      default: begin
        add_result(swlfc_pkg::KIND_IGNORED, ev.seq, 3'd0);
      end
    endcase
    r = step_results.pop_back();
    r.last = 1'b1;
    step_results.push_back(r);
    foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  function automatic swlfc_pkg::in_item_t link_event(input logic [2:0] op,
                                                     input logic [7:0] seqv,
                                                     input logic [7:0] pexp);
    swlfc_pkg::in_item_t ev;
    ev.op            = op;
    ev.seq           = seqv;
    ev.peer_expected = pexp;
    return ev;
  endfunction

  // Picks one event that mostly fits the current window state, so that the
  // random part exercises real acknowledgement, reordering and retransmit
  // traffic. A small share is plain noise.
  function automatic swlfc_pkg::in_item_t pick_event();
    swlfc_pkg::in_item_t ev;
    int                  r;
    int                  start;
    int                  idx;
    bit                  found;
    logic [7:0]          span;
    ev.op            = swlfc_pkg::OP_SEND;
    ev.seq           = 8'($urandom);
    ev.peer_expected = 8'($urandom);
    r     = $urandom_range(0, 99);
    span  = link_last_sent - link_last_acked;
    found = 1'b0;
    if (r < 30) begin
      ev.op = swlfc_pkg::OP_SEND;
    end else if (r < 50) begin
      ev.op = swlfc_pkg::OP_ACK;
      if (span != 0 && r < 46) begin
        ev.seq = link_last_acked + 8'd1 + 8'($urandom_range(0, span - 1));
      end
    end else if (r < 75) begin
      ev.op = swlfc_pkg::OP_DATA;
      if (r < 72) begin
        ev.seq = link_next_rx + 8'($urandom_range(0, RW - 1));
      end
    end else if (r < 85) begin
      ev.op = swlfc_pkg::OP_TIMEOUT;
      if (r < 83) begin
        start = $urandom_range(0, SW - 1);
        for (int k = 0; k < SW; k++) begin
          idx = (start + k) % SW;
          if (!found && link_held[idx]) begin
            ev.seq = link_slot_seq[idx];
            found  = 1'b1;
          end
        end
      end
    end else if (r < 90) begin
      ev.op = swlfc_pkg::OP_SYNC;
    end else if (r < 95) begin
      ev.op = 3'($urandom_range(5, 7));
    end else begin
      ev.op = 3'($urandom_range(0, 7));
    end
    // Never aim a timeout at a slot whose number memory was never written.
    if (ev.op == swlfc_pkg::OP_TIMEOUT && !link_slot_written[tx_slot(ev.seq)]) begin
      ev.op = swlfc_pkg::OP_SEND;
    end
    return ev;
  endfunction

  // Offers one event and waits for its transfer. Valid is only dropped for
  // an idle gap, so back-to-back events keep it high across the edge.
  task automatic send_event(input swlfc_pkg::in_item_t ev);
    int gap;
    gap = 0;
    if (!quiet_mode && !tx_steady && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_item_i  <= ev;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_link_event(ev);
    events_sent++;
  endtask

  // The sender stops until every expected result has come out, then lets the
  // back end settle for the drain period.
  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver. Ready idles in short random bursts, with calm stretches where
  // it stays high, and serves a long hold-off when a test asks for one. The
  // hold-off is counted here in clock cycles.
  // --------------------------------------------------------------------------
  initial begin
    int hold;
    int rx_phase;
    rx_phase = 0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (rx_hold_cycles > 0) begin
        hold = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (!quiet_mode && !rx_calm && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
      rx_phase++;
      if (rx_phase % 64 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      @(posedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker. Each output transfer is compared field by field with the
  // oldest expected result. Values are sampled right after the edge, before
  // the block's registers update, so they are the ones seen by the transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected (kind %0d seq %0d)",
                                  results_seen, out_item_o.kind, out_item_o.seq_out));
      end else begin
        want_result = pending_results.pop_front();
        kind_seen[want_result.kind]++;
        if (out_item_o.kind !== want_result.kind)
          report_mismatch($sformatf("result %0d kind: got %0d, expected %0d",
                                    results_seen, out_item_o.kind, want_result.kind));
        if (out_item_o.seq_out !== want_result.seq_out)
          report_mismatch($sformatf("result %0d seq_out: got %0d, expected %0d",
                                    results_seen, out_item_o.seq_out, want_result.seq_out));
        if (out_item_o.slot !== want_result.slot)
          report_mismatch($sformatf("result %0d slot: got %0d, expected %0d",
                                    results_seen, out_item_o.slot, want_result.slot));
        if (out_item_o.last !== want_result.last)
          report_mismatch($sformatf("result %0d last: got %0d, expected %0d",
                                    results_seen, out_item_o.last, want_result.last));
      end
    end
  end

  // Watchdog: any cycle with a transfer on either channel restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles = 0;
    end else begin
      if (in_valid_i && !in_ready_o) input_stalls++;
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("[%0t] no transfer for %0d cycles, %0d results still expected",
                   $time, idle_cycles, pending_results.size());
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Corner cases straight after reset and around wrap-around, one of each
  // event kind and each result kind.
  task automatic test_directed_cases();
    // A frame for number zero is in order right after reset.
    send_event(link_event(swlfc_pkg::OP_DATA, 8'h00, 8'h00));
    // Nothing is outstanding yet, so this ack is ignored.
    send_event(link_event(swlfc_pkg::OP_ACK, 8'h05, 8'h00));
    send_event(link_event(swlfc_pkg::OP_SEND, 8'h00, 8'h00));
    // Retransmit of a held slot, then a timeout for the same slot under
    // another number, which must be ignored.
    send_event(link_event(swlfc_pkg::OP_TIMEOUT, 8'h01, 8'h00));
    send_event(link_event(swlfc_pkg::OP_TIMEOUT, 8'h09, 8'h00));
    // Fill the send window and push one more, which is refused.
    repeat (SW - 1) send_event(link_event(swlfc_pkg::OP_SEND, 8'hFF, 8'hFF));
    send_event(link_event(swlfc_pkg::OP_SEND, 8'h00, 8'h00));
    // One cumulative ack frees the whole window.
    send_event(link_event(swlfc_pkg::OP_ACK, 8'h08, 8'h00));
    // Sync across the top of the number space; the synack wraps to zero.
    send_event(link_event(swlfc_pkg::OP_SYNC, 8'hFF, 8'h00));
    send_event(link_event(swlfc_pkg::OP_ACK, 8'h00, 8'h00));
    // Out-of-order frames, one just past the receive window, then the
    // in-order frame, delivered alone since number zero never arrives.
    send_event(link_event(swlfc_pkg::OP_DATA, 8'h01, 8'h00));
    send_event(link_event(swlfc_pkg::OP_DATA, 8'h06, 8'h00));
    send_event(link_event(swlfc_pkg::OP_DATA, 8'h07, 8'h00));
    send_event(link_event(swlfc_pkg::OP_DATA, 8'hFF, 8'h00));
    // Undefined event codes are ignored.
    send_event(link_event(3'd5, 8'hAA, 8'h55));
    send_event(link_event(3'd6, 8'h55, 8'hAA));
    send_event(link_event(3'd7, 8'hFF, 8'hFF));
    // Sync with the largest peer number, then a retransmit of its synack.
    send_event(link_event(swlfc_pkg::OP_SYNC, 8'h80, 8'hFF));
    send_event(link_event(swlfc_pkg::OP_TIMEOUT, 8'hFF, 8'h00));
    pause_until_drained();
  endtask

  // Random sessions: each starts with a sync and continues with traffic that
  // mostly fits the windows. Some sessions run the sender without gaps, and
  // some end with the sender waiting for all results.
  task automatic test_random_sessions(input int target);
    int n;
    int len;
    n = 0;
    while (n < target) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      send_event(link_event(swlfc_pkg::OP_SYNC, 8'($urandom), 8'($urandom)));
      n++;
      len = $urandom_range(10, 40);
      for (int k = 0; k < len; k++) begin
        send_event(pick_event());
        n++;
      end
      if ($urandom_range(0, 2) == 0) pause_until_drained();
    end
    tx_steady = 1'b0;
    pause_until_drained();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering, so the front register and queue fill and the input stalls.
  // The burst includes an ack that frees a full window after the synack.
  task automatic test_receiver_backpressure();
    tx_steady      = 1'b1;
    rx_hold_cycles = HOLD_CYCLES;
    send_event(link_event(swlfc_pkg::OP_SYNC, 8'($urandom), 8'($urandom)));
    repeat (SW) send_event(link_event(swlfc_pkg::OP_SEND, 8'($urandom), 8'($urandom)));
    send_event(link_event(swlfc_pkg::OP_ACK, link_last_sent, 8'($urandom)));
    repeat (12) send_event(pick_event());
    tx_steady = 1'b0;
    pause_until_drained();
  endtask

  // Last part of the run: no idling on either side.
  task automatic test_idle_free_stream(input int count);
    quiet_mode = 1'b1;
    repeat (count) send_event(pick_event());
    pause_until_drained();
  endtask

  initial begin
    clear_link_model();
    foreach (kind_seen[i]) kind_seen[i] = 0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_sessions(300);
    test_receiver_backpressure();
    test_idle_free_stream(60);

    $display("Run covered %0d link events and %0d result transfers, %0d cycles of input stall.",
             events_sent, results_seen, input_stalls);
    $display({"Results by kind: new %0d, retx %0d, freed %0d, deliver %0d, ",
              "ack %0d, conn %0d, refused %0d, ignored %0d."},
             kind_seen[swlfc_pkg::KIND_TX_NEW], kind_seen[swlfc_pkg::KIND_RETX],
             kind_seen[swlfc_pkg::KIND_FREED], kind_seen[swlfc_pkg::KIND_DELIVER],
             kind_seen[swlfc_pkg::KIND_SEND_ACK], kind_seen[swlfc_pkg::KIND_CONNECTED],
             kind_seen[swlfc_pkg::KIND_REFUSED], kind_seen[swlfc_pkg::KIND_IGNORED]);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sliding_window_link_flow_control_top.f
rtl/core/swlfc_pkg.sv
rtl/core/swlfc_front.sv
rtl/core/swlfc_queue.sv
rtl/core/swlfc_back.sv
rtl/core/sliding_window_link_flow_control_top.sv
bench/tb_sliding_window_link_flow_control_top.sv
